// File: design/ted_pkg.sv
package ted_pkg;

    // Parser modes, one-hot
    typedef enum logic [3:0] {
        MODE_GROUND = 4'b0001,
        MODE_ESC    = 4'b0010,
        MODE_CSI    = 4'b0100,
        MODE_CSIEQ  = 4'b1000
    } t_mode;

    // Command tokens to the display sink
    typedef enum logic [3:0] {
        CMD_PRINT   = 4'd0,
        CMD_CRLF    = 4'd1,
        CMD_CLR_EOS = 4'd2,
        CMD_CLR_EOL = 4'd3,
        CMD_COL     = 4'd4,
        CMD_GOTO    = 4'd5,
        CMD_DOWN    = 4'd6,
        CMD_UP      = 4'd7,
        CMD_RIGHT   = 4'd8,
        CMD_LEFT    = 4'd9,
        CMD_DELCH   = 4'd10,
        CMD_DELLN   = 4'd11,
        CMD_INSCH   = 4'd12,
        CMD_INSLN   = 4'd13,
        CMD_ATTR    = 4'd14,
        CMD_SHOWCUR = 4'd15
    } t_cmd;

    // Characters
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_GRAVE = 8'h60;
    localparam logic [7:0] CH_LC_M  = 8'h6D;

    // Attribute word
    localparam logic [15:0] ATTR_RESET   = 16'h0007;
    localparam logic [15:0] ATTR_FG_MASK = 16'h000F;
    localparam logic [15:0] ATTR_FG_WHT  = 16'h0007;
    localparam logic [15:0] ATTR_BRIGHT  = 16'h0008;
    localparam logic [15:0] ATTR_REVERSE = 16'h4000;

    // SGR parameter codes
    localparam int SGR_RESET   = 0;
    localparam int SGR_BOLD    = 1;
    localparam int SGR_NORMAL  = 2;
    localparam int SGR_REVERSE = 7;

    localparam logic [3:0] SEP_MAX = 4'hF;

    typedef struct packed {
        logic        valid;
        t_cmd        cmd;
        logic [7:0]  char_out;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
        logic [15:0] attr_out;
    } t_result;

endpackage

// File: design/ted_parser.sv
module ted_parser import ted_pkg::*; #(
    parameter int VALUE_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    localparam int VB = VALUE_BITS;

    t_mode            r_mode, n_mode;
    logic [3:0]       r_sep, n_sep;
    logic [VB-1:0]    r_first, n_first;
    logic [VB-1:0]    r_second, n_second;
    logic [15:0]      r_attr, n_attr;

    logic             w_digit, w_semi, w_collect;
    logic [VB+3:0]    w_f10, w_s10;
    logic [VB-1:0]    w_f_acc, w_s_acc;
    logic [VB+15:0]   w_f_wide, w_s_wide;
    logic [15:0]      w_f_trunc, w_f_or1, w_s_or1;
    logic [3:0]       c_sep;
    logic [VB-1:0]    c_first, c_second;
    logic [15:0]      w_attr_upd;

    // digit accumulate: v*10 + d, saturating
    assign w_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_semi  = (i_byte == CH_SEMI);
    assign w_collect = w_digit || w_semi;

    assign w_f10 = {1'b0, r_first, 3'b000} + {3'b000, r_first, 1'b0}
                 + (VB+4)'(i_byte[3:0]);
    assign w_s10 = {1'b0, r_second, 3'b000} + {3'b000, r_second, 1'b0}
                 + (VB+4)'(i_byte[3:0]);
    assign w_f_acc = (|w_f10[VB+3:VB]) ? '1 : w_f10[VB-1:0];
    assign w_s_acc = (|w_s10[VB+3:VB]) ? '1 : w_s10[VB-1:0];

    assign w_f_wide  = {16'b0, r_first};
    assign w_s_wide  = {16'b0, r_second};
    assign w_f_trunc = w_f_wide[15:0];
    assign w_f_or1   = (r_first  == '0) ? 16'd1 : w_f_trunc;
    assign w_s_or1   = (r_second == '0) ? 16'd1 : w_s_wide[15:0];

    always_comb begin
        c_sep    = r_sep;
        c_first  = r_first;
        c_second = r_second;
        if (w_digit) begin
            if (r_sep == 4'd0) begin
                c_first = w_f_acc;
            end else if (r_sep == 4'd1) begin
                c_second = w_s_acc;
            end
        end else if (w_semi && (r_sep != SEP_MAX)) begin
            c_sep = r_sep + 4'd1;
        end
    end

    always_comb begin
        w_attr_upd = r_attr;
        if (r_first == VB'(SGR_RESET)) begin
            w_attr_upd = (r_attr & ~ATTR_FG_MASK) | ATTR_FG_WHT;
        end else if (r_first == VB'(SGR_BOLD)) begin
            w_attr_upd = r_attr | ATTR_BRIGHT;
        end else if (r_first == VB'(SGR_NORMAL)) begin
            w_attr_upd = r_attr & ~ATTR_BRIGHT;
        end else if (r_first == VB'(SGR_REVERSE)) begin
            w_attr_upd = r_attr | ATTR_REVERSE;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_sep    = r_sep;
        n_first  = r_first;
        n_second = r_second;
        n_attr   = r_attr;
        o_res    = '{valid: 1'b0, cmd: CMD_PRINT, char_out: 8'h00,
                     arg_a: 16'h0000, arg_b: 16'h0000, attr_out: 16'h0000};

        if ((i_byte == CH_BEL) || (i_byte == CH_BS) || (i_byte == CH_TAB)
            || (i_byte == CH_CR)) begin
            o_res.valid    = 1'b1;
            o_res.char_out = i_byte;
        end else if ((i_byte == CH_LF) || (i_byte == CH_FF) || (i_byte == CH_VT)) begin
            o_res.valid    = 1'b1;
            o_res.char_out = CH_LF;
        end else begin
            unique case (r_mode)
                MODE_GROUND: begin
                    if (i_byte == CH_ESC) begin
                        n_mode = MODE_ESC;
                    end else begin
                        o_res.valid    = 1'b1;
                        o_res.char_out = i_byte;
                    end
                end
                MODE_ESC: begin
                    if (i_byte == CH_LBRK) begin
                        n_mode   = MODE_CSI;
                        n_sep    = '0;
                        n_first  = '0;
                        n_second = '0;
                    end else begin
                        n_mode = MODE_GROUND;
                    end
                end
                MODE_CSI: begin
                    if (i_byte == CH_EQ) begin
                        n_mode = MODE_CSIEQ;
                    end else if (w_collect) begin
                        n_sep    = c_sep;
                        n_first  = c_first;
                        n_second = c_second;
                    end else begin
                        n_mode = MODE_GROUND;
                        o_res.valid = 1'b1;
                        unique case (i_byte)
                            CH_J:     o_res.cmd = CMD_CLR_EOS;
                            CH_K:     o_res.cmd = CMD_CLR_EOL;
                            CH_GRAVE: begin
                                o_res.cmd   = CMD_COL;
                                o_res.arg_a = w_f_or1;
                            end
                            CH_H: begin
                                o_res.cmd   = CMD_GOTO;
                                o_res.arg_a = w_f_or1;
                                o_res.arg_b = w_s_or1;
                            end
                            CH_B: begin
                                o_res.cmd   = CMD_DOWN;
                                o_res.arg_a = w_f_or1;
                            end
                            CH_A: begin
                                o_res.cmd   = CMD_UP;
                                o_res.arg_a = w_f_or1;
                            end
                            CH_C: begin
                                o_res.cmd   = CMD_RIGHT;
                                o_res.arg_a = w_f_or1;
                            end
                            CH_D: begin
                                o_res.cmd   = CMD_LEFT;
                                o_res.arg_a = w_f_or1;
                            end
                            CH_E:     o_res.cmd = CMD_CRLF;
                            CH_P:     o_res.cmd = CMD_DELCH;
                            CH_M:     o_res.cmd = CMD_DELLN;
                            CH_AT:    o_res.cmd = CMD_INSCH;
                            CH_L:     o_res.cmd = CMD_INSLN;
                            CH_LC_M: begin
                                o_res.cmd      = CMD_ATTR;
                                o_res.attr_out = w_attr_upd;
                                n_attr         = w_attr_upd;
                            end
                            default:  o_res.valid = 1'b0;
                        endcase
                    end
                end
                MODE_CSIEQ: begin
                    if (w_collect) begin
                        n_sep    = c_sep;
                        n_first  = c_first;
                        n_second = c_second;
                    end else begin
                        n_mode = MODE_GROUND;
                        if (i_byte == CH_C) begin
                            o_res.valid = 1'b1;
                            o_res.cmd   = CMD_SHOWCUR;
                            o_res.arg_a = w_f_trunc;
                        end
                    end
                end
                default: n_mode = MODE_GROUND;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_GROUND;
            r_sep    <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_attr   <= ATTR_RESET;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_sep    <= n_sep;
            r_first  <= n_first;
            r_second <= n_second;
            r_attr   <= n_attr;
        end
    end

endmodule

// File: design/terminal_escape_decoder.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-------------------------------------------
// in       | sink      | i_in_valid / o_in_ready | i_byte_in
// out      | source    | o_out_valid/i_out_ready | o_cmd, o_char_out, o_arg_a, o_arg_b,
//          |           |                         | o_attr_out
//
// One request per clock unless the result stalls. A byte is captured in the input
// register, then decoded, and its token (if any) lands in the result register.
// Reset (synchronous, active low) empties both registers, puts the parser in ground
// mode and sets the attribute word to white on black.
// A stalled result holds the input register; one byte is still taken while the
// result waits, after which o_in_ready drops until the sink takes the token.
module terminal_escape_decoder import ted_pkg::*; #(
    parameter int VALUE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_cmd,
    output logic [7:0]  o_char_out,
    output logic [15:0] o_arg_a,
    output logic [15:0] o_arg_b,
    output logic [15:0] o_attr_out
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_res;
    t_result    w_res;
    logic       w_adv;

    // Byte moves to the parser when the result slot is free or being emptied;
    // bytes with no token still wait for that, keeping one simple rule.
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_byte_in;
        end
    end

    ted_parser #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.valid) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = r_res.cmd;
    assign o_char_out  = r_res.char_out;
    assign o_arg_a     = r_res.arg_a;
    assign o_arg_b     = r_res.arg_b;
    assign o_attr_out  = r_res.attr_out;

    // Only print tokens carry a character
    a_char_print_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.cmd != CMD_PRINT)) |-> (r_res.char_out == 8'h00))
        else $error("character on non-print token");

    // Only goto carries a second argument
    a_argb_goto_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.cmd != CMD_GOTO)) |-> (r_res.arg_b == 16'h0000))
        else $error("second argument on non-goto token");

    // Attribute word never loses its low foreground bits
    a_attr_fg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.cmd == CMD_ATTR)) |-> (r_res.attr_out[2:0] == 3'b111))
        else $error("attribute word lost foreground bits");

    // A held byte stays put while the result side is stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input byte changed");

    // Not ready only while a byte is held and the result is stalled
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without cause");

endmodule

// File: sim/ted_token_checker.sv
// Watches both channels of the escape decoder, predicts the token for each
// accepted byte and compares every token the sink takes against the oldest
// prediction still waiting.
module ted_token_checker import ted_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_byte_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_cmd,
    input  logic [7:0]  i_char_out,
    input  logic [15:0] i_arg_a,
    input  logic [15:0] i_arg_b,
    input  logic [15:0] i_attr_out,
    output int          o_mismatches,
    output int          o_outstanding,
    output int          o_tokens_checked,
    output logic [15:0] o_cmds_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] PARAM_CEILING = 16'hFFFF;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  ch;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
        logic [15:0] attr;
    } t_token;

    t_token      expected_tokens[$];
    t_token      want;
    int          mismatches     = 0;
    int          tokens_checked = 0;
    logic [15:0] cmds_seen      = '0;

    // shadow parser state
    t_mode       mode_q;
    logic [3:0]  seps_q;
    logic [15:0] par1_q;
    logic [15:0] par2_q;
    logic [15:0] attr_q;

    assign o_mismatches     = mismatches;
    assign o_tokens_checked = tokens_checked;
    assign o_cmds_seen      = cmds_seen;

    function automatic logic [15:0] push_digit(input logic [15:0] v, input logic [7:0] c);
        int unsigned n;
        n = 32'(v) * 32'd10 + 32'(c - CH_ZERO);
        return (n > 32'(PARAM_CEILING)) ? PARAM_CEILING : n[15:0];
    endfunction

    // digits and separators; only the first two parameters are kept
    function automatic bit collect_param(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            if (seps_q == 4'd0)
                par1_q = push_digit(par1_q, c);
            else if (seps_q == 4'd1)
                par2_q = push_digit(par2_q, c);
            return 1'b1;
        end
        if (c == CH_SEMI) begin
            if (seps_q != SEP_MAX)
                seps_q = seps_q + 4'd1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic bit decode_byte(input logic [7:0] c, output t_token tok);
        tok = '0;
        tok.cmd = CMD_PRINT;
        if (c == CH_BEL || c == CH_BS || c == CH_TAB || c == CH_CR) begin
            tok.ch = c;
            return 1'b1;
        end
        if (c == CH_LF || c == CH_FF || c == CH_VT) begin
            tok.ch = CH_LF;
            return 1'b1;
        end
        case (mode_q)
            MODE_GROUND: begin
                if (c == CH_ESC) begin
                    mode_q = MODE_ESC;
                    return 1'b0;
                end
                tok.ch = c;
                return 1'b1;
            end
            MODE_ESC: begin
                if (c == CH_LBRK) begin
                    mode_q = MODE_CSI;
                    seps_q = '0;
                    par1_q = '0;
                    par2_q = '0;
                end else begin
                    mode_q = MODE_GROUND;
                end
                return 1'b0;
            end
            MODE_CSI: begin
                if (c == CH_EQ) begin
                    mode_q = MODE_CSIEQ;
                    return 1'b0;
                end
                if (collect_param(c))
                    return 1'b0;
                mode_q = MODE_GROUND;
                case (c)
                    CH_J:     tok.cmd = CMD_CLR_EOS;
                    CH_K:     tok.cmd = CMD_CLR_EOL;
                    CH_E:     tok.cmd = CMD_CRLF;
                    CH_P:     tok.cmd = CMD_DELCH;
                    CH_M:     tok.cmd = CMD_DELLN;
                    CH_AT:    tok.cmd = CMD_INSCH;
                    CH_L:     tok.cmd = CMD_INSLN;
                    CH_GRAVE: begin
                        tok.cmd   = CMD_COL;
                        tok.arg_a = at_least_one(par1_q);
                    end
                    CH_H: begin
                        tok.cmd   = CMD_GOTO;
                        tok.arg_a = at_least_one(par1_q);
                        tok.arg_b = at_least_one(par2_q);
                    end
                    CH_B: begin
                        tok.cmd   = CMD_DOWN;
                        tok.arg_a = at_least_one(par1_q);
                    end
                    CH_A: begin
                        tok.cmd   = CMD_UP;
                        tok.arg_a = at_least_one(par1_q);
                    end
                    CH_C: begin
                        tok.cmd   = CMD_RIGHT;
                        tok.arg_a = at_least_one(par1_q);
                    end
                    CH_D: begin
                        tok.cmd   = CMD_LEFT;
                        tok.arg_a = at_least_one(par1_q);
                    end
                    CH_LC_M: begin
                        if (par1_q == SGR_RESET)
                            attr_q = (attr_q & ~ATTR_FG_MASK) | ATTR_FG_WHT;
                        else if (par1_q == SGR_BOLD)
                            attr_q = attr_q | ATTR_BRIGHT;
                        else if (par1_q == SGR_NORMAL)
                            attr_q = attr_q & ~ATTR_BRIGHT;
                        else if (par1_q == SGR_REVERSE)
                            attr_q = attr_q | ATTR_REVERSE;
                        tok.cmd  = CMD_ATTR;
                        tok.attr = attr_q;
                    end
                    default:  return 1'b0;
                endcase
                return 1'b1;
            end
            default: begin
                // ESC [ = : parameters from ESC [ carry over
                if (collect_param(c))
                    return 1'b0;
                mode_q = MODE_GROUND;
                if (c == CH_C) begin
                    tok.cmd   = CMD_SHOWCUR;
                    tok.arg_a = par1_q;
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q = MODE_GROUND;
            seps_q = '0;
            par1_q = '0;
            par2_q = '0;
            attr_q = ATTR_RESET;
            expected_tokens.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (decode_byte(i_byte_in, want))
                    expected_tokens.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token with none expected: cmd 0x%0h char 0x%0h", i_cmd, i_char_out);
                    mismatches++;
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("cmd", 16'(want.cmd), 16'(i_cmd));
                    check_field("char_out", 16'(want.ch), 16'(i_char_out));
                    check_field("arg_a", want.arg_a, i_arg_a);
                    check_field("arg_b", want.arg_b, i_arg_b);
                    check_field("attr_out", want.attr, i_attr_out);
                    tokens_checked++;
                    cmds_seen[i_cmd] = 1'b1;
                end
            end
        end
        o_outstanding <= expected_tokens.size();
    end

endmodule

// File: sim/terminal_escape_decoder_test.sv
// Stimulus and verdict for the escape decoder. The checker beside the block
// does all prediction and comparison; this module only feeds bytes, plays the
// display sink and reports.
module terminal_escape_decoder_test import ted_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES   = 60;   // long sink hold-off
    localparam int SETTLE_CYCLES = 8;    // input and result registers plus margin
    localparam int PHASE_BYTES   = 320;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_byte_in   = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_cmd;
    logic [7:0]  o_char_out;
    logic [15:0] o_arg_a;
    logic [15:0] o_arg_b;
    logic [15:0] o_attr_out;

    int          mismatches;
    int          outstanding;
    int          tokens_checked;
    logic [15:0] cmds_seen;

    // idling knobs, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit long_hold_req  = 1'b0;
    int bytes_sent     = 0;

    logic [7:0] seq_bytes[$];

    // idling per phase: none, sender sparse, sink stalling, both
    int phase_send_idle[4]  = '{0, 82, 0, 30};
    int phase_recv_stall[4] = '{0, 0, 82, 30};

    logic [7:0] csi_finals[14] = '{CH_J, CH_K, CH_GRAVE, CH_H, CH_B, CH_A, CH_C, CH_D,
                                   CH_E, CH_P, CH_M, CH_AT, CH_L, CH_LC_M};
    logic [7:0] ctrl_chars[7]  = '{CH_BEL, CH_BS, CH_TAB, CH_CR, CH_LF, CH_VT, CH_FF};
    int         sgr_codes[4]   = '{SGR_RESET, SGR_BOLD, SGR_NORMAL, SGR_REVERSE};

    // Directed opener: byte extremes, pass-through controls, a goto whose row
    // saturates, whose column is missing (so 1) and whose third parameter is
    // ignored, a line feed in the middle of a CSI, show cursor with the
    // parameter carried across '=', and an attribute reset.
    logic [7:0] directed_bytes[25] = '{
        8'h00, 8'hFF, CH_BEL, CH_VT,
        CH_ESC, CH_LBRK, CH_ZERO + 8'd7, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO,
        CH_SEMI, CH_LF, CH_SEMI, CH_ZERO + 8'd3, CH_H,
        CH_ESC, CH_LBRK, CH_ZERO + 8'd2, CH_EQ, CH_C,
        CH_ESC, CH_LBRK, CH_LC_M
    };

    terminal_escape_decoder uut (.*);

    ted_token_checker token_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_byte_in       (i_byte_in),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_cmd           (o_cmd),
        .i_char_out      (o_char_out),
        .i_arg_a         (o_arg_a),
        .i_arg_b         (o_arg_b),
        .i_attr_out      (o_attr_out),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding),
        .o_tokens_checked(tokens_checked),
        .o_cmds_seen     (cmds_seen)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Sink: random stalls, or one long hold-off when asked for. The hold-off
    // is counted here so the sender keeps offering requests meanwhile.
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Called at a rising edge. Valid stays high from one request into the next
    // unless an idle cycle is drawn, so it is never dropped and raised in one step.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Parameter list: mostly short numbers, some long enough to saturate,
    // empty fields, and now and then a flood of separators.
    task automatic add_params();
        int n;
        int k;
        int nd;
        if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(14, 18)) seq_bytes.push_back(CH_SEMI);
            seq_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
            return;
        end
        n = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            if (i > 0)
                seq_bytes.push_back(CH_SEMI);
            k  = $urandom_range(9);
            nd = (k < 7) ? $urandom_range(2) : (k < 9) ? $urandom_range(3, 5)
                                                     : $urandom_range(6, 7);
            repeat (nd) seq_bytes.push_back(CH_ZERO + 8'($urandom_range(9)));
        end
    endtask

    // One random sequence: mostly well-formed CSI with random content, plus
    // plain text, ESC [ = sequences, stray ESC pairs and raw noise. Control
    // characters are sprinkled anywhere, mid-sequence included.
    task automatic send_sequence();
        int         kind;
        logic [7:0] fin;
        kind = $urandom_range(99);
        seq_bytes.delete();
        if (kind < 18) begin
            repeat ($urandom_range(1, 4)) seq_bytes.push_back(8'($urandom_range(32, 126)));
        end else if (kind < 72) begin
            fin = ($urandom_range(9) == 0) ? 8'($urandom) : csi_finals[$urandom_range(13)];
            seq_bytes.push_back(CH_ESC);
            seq_bytes.push_back(CH_LBRK);
            if (fin == CH_LC_M && $urandom_range(1) == 1)
                seq_bytes.push_back(CH_ZERO + 8'(sgr_codes[$urandom_range(3)]));
            else
                add_params();
            seq_bytes.push_back(fin);
        end else if (kind < 84) begin
            seq_bytes.push_back(CH_ESC);
            seq_bytes.push_back(CH_LBRK);
            if ($urandom_range(1) == 1)
                add_params();
            seq_bytes.push_back(CH_EQ);
            add_params();
            seq_bytes.push_back(($urandom_range(4) != 0) ? CH_C : 8'($urandom));
        end else if (kind < 92) begin
            seq_bytes.push_back(CH_ESC);
            seq_bytes.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 3)) seq_bytes.push_back(8'($urandom));
        end
        while (seq_bytes.size() != 0) begin
            if ($urandom_range(99) < 4)
                send_byte(ctrl_chars[$urandom_range(6)]);
            send_byte(seq_bytes.pop_front());
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = phase_send_idle[p];
            recv_stall_pct = phase_recv_stall[p];
            // sink holds off while a burst of text keeps arriving: the block
            // fills and must stall its input
            long_hold_req = 1'b1;
            repeat (16) send_byte(8'($urandom_range(32, 126)));
            while (bytes_sent < 25 + (p + 1) * PHASE_BYTES)
                send_sequence();
        end

        // last request accepted at this edge; drain and let the pipe settle
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d bytes fed through four idling phases, each opened by a long sink hold-off",
                 bytes_sent);
        $display("%0d tokens compared, %0d of 16 command kinds seen",
                 tokens_checked, $countones(cmds_seen));
        if (mismatches == 0 && outstanding == 0) begin
            $display("terminal_escape_decoder: match");
        end else begin
            $display("terminal_escape_decoder: mismatch");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("terminal_escape_decoder: mismatch");
        $finish;
    end

endmodule
